// ===== rtl/palette_ramdac_registers_assert.svh =====
`ifndef PALETTE_RAMDAC_REGISTERS_ASSERT_SVH
`define PALETTE_RAMDAC_REGISTERS_ASSERT_SVH

// checked at every clock edge, reset included
`define PRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// checked only outside reset
`define PRD_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/prd_pkg.sv =====
package prd_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_PIXEL = 2'd2;

  localparam logic [3:0] RA_WADDR = 4'd0;
  localparam logic [3:0] RA_DATA  = 4'd1;
  localparam logic [3:0] RA_MASK  = 4'd2;
  localparam logic [3:0] RA_RADDR = 4'd3;
  localparam logic [3:0] RA_GCTL  = 4'd8;
  localparam logic [3:0] RA_ICLK  = 4'd9;
  localparam logic [3:0] RA_OCLK  = 4'd10;
  localparam logic [3:0] RA_MUX   = 4'd11;
  localparam logic [3:0] RA_PAGE  = 4'd12;
  localparam logic [3:0] RA_TEST  = 4'd14;
  localparam logic [3:0] RA_RESET = 4'd15;

  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] addr;
    logic [23:0]       data;
  } pal_wr_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
  } pal_rd_t;

  // power-on and soft-reset value of one register
  function automatic logic [7:0] reg_default(input logic [3:0] a);
    logic [7:0] v;
    case (a)
      RA_MASK: v = 8'hff;
      RA_GCTL: v = 8'h03;
      RA_OCLK: v = 8'h3f;
      RA_MUX:  v = 8'h2d;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // byte reduced modulo the palette size, by restoring subtraction
  function automatic logic [PAL_AW-1:0] pal_index(input logic [7:0] v);
    logic [11:0] t;
    t = {4'd0, v};
    for (int k = 3; k >= 0; k--) begin
      if (t >= 12'(PALETTE_ENTRIES << k)) begin
        t = t - 12'(PALETTE_ENTRIES << k);
      end
    end
    return t[PAL_AW-1:0];
  endfunction

endpackage

// ===== rtl/prd_palette_mem.sv =====
module prd_palette_mem
  import prd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pal_wr_t     wr,
  input  pal_rd_t     rd,
  output logic [23:0] rd_data
);

  logic [23:0] mem [PALETTE_ENTRIES];
  logic [23:0] rd_q_r;
  logic [23:0] fwd_r;
  logic        hit_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_q_r <= mem[rd.addr];
      fwd_r  <= wr.data;
    end
  end

  // read and write of the same entry in one cycle returns the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (rd.en) begin
      hit_r <= wr.we && (wr.addr == rd.addr);
    end
  end

  assign rd_data = hit_r ? fwd_r : rd_q_r;

endmodule

// ===== rtl/palette_ramdac_registers.sv =====
// Palette DAC register block.
// Input channel (in_valid / in_stall): one item is a register read, a register
// write or a pixel lookup, selected by in_req_type. Every item gives exactly
// one result item on the output channel (out_valid / out_stall): a read
// returns its byte on out_read_data, a lookup returns out_red_out,
// out_green_out and out_blue_out, all other fields are zero.
// Throughput: one item per cycle, pixels and bus accesses alike, unless the
// receiver stalls; the palette RAM is read as the item is accepted and its
// registered data is used in the input stage, where all state is updated as
// the item moves to the output stage. Configuration: cfg_wr_en / cfg_wr_data
// write the 8-bit mode bit; the user must write it only while the block is
// idle (not enforced); 1 takes palette bytes as is, 0 widens 6-bit values.
// Reset (rst_n low at a clock edge) empties both stages, loads the register
// defaults, clears the phases and the staging triplet and sets 8-bit mode.
// The palette RAM is not cleared; an entry must be written before it is read.
// When the receiver stalls, the result holds on the outputs, one more item
// may enter the input stage, and then in_stall rises until the result leaves.
module palette_ramdac_registers
  import prd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [3:0] in_reg_addr,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_pixel_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out
);

  function automatic logic [7:0] widen6(input logic [7:0] v);
    return {v[5:0], v[5:4]};
  endfunction

  logic       dac_eight_bit_r;
  logic [7:0] regs_r   [16];
  logic [7:0] regs_nxt [16];
  logic [7:0] trip_r   [3];
  logic [7:0] trip_nxt [3];
  logic [1:0] wph_r, wph_nxt;
  logic [1:0] rph_r, rph_nxt;

  logic       ex_valid_r;
  logic [1:0] ex_req_r;
  logic [3:0] ex_ra_r;
  logic [7:0] ex_wd_r;
  logic [7:0] ex_px_r;

  logic       out_valid_r;
  logic [7:0] out_rd_r, out_r_r, out_g_r, out_b_r;
  logic [7:0] res_rd, res_r, res_g, res_b;

  logic        ex_fire;
  logic        in_accept;
  logic [7:0]  raddr_eff;
  logic [23:0] pal_q;
  pal_wr_t     pal_wr;
  pal_rd_t     pal_rd;

  assign ex_fire   = ex_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = ex_valid_r && !ex_fire;
  assign in_accept = in_valid && !in_stall;

  assign raddr_eff   = ex_fire ? regs_nxt[RA_RADDR] : regs_r[RA_RADDR];
  assign pal_rd.en   = in_accept;
  assign pal_rd.addr = pal_index((in_req_type == REQ_PIXEL) ? in_pixel_index : raddr_eff);

  prd_palette_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (pal_wr),
    .rd      (pal_rd),
    .rd_data (pal_q)
  );

  always_comb begin
    regs_nxt   = regs_r;
    trip_nxt   = trip_r;
    wph_nxt    = wph_r;
    rph_nxt    = rph_r;
    pal_wr.we  = 1'b0;
    pal_wr.addr = pal_index(regs_r[RA_WADDR]);
    pal_wr.data = {trip_r[0], trip_r[1], trip_r[2]};
    res_rd     = 8'd0;
    res_r      = 8'd0;
    res_g      = 8'd0;
    res_b      = 8'd0;
    case (ex_req_r)
      REQ_READ: begin
        res_rd = regs_r[ex_ra_r];
        if (ex_ra_r == RA_DATA) begin
          if (rph_r == 2'd0) begin
            trip_nxt = '{pal_q[23:16], pal_q[15:8], pal_q[7:0]};
          end
          res_rd = trip_nxt[rph_r];
          if (rph_r == 2'd2) begin
            rph_nxt = 2'd0;
            regs_nxt[RA_RADDR] = regs_r[RA_RADDR] + 8'd1;
          end else begin
            rph_nxt = rph_r + 2'd1;
          end
        end
      end
      REQ_WRITE: begin
        regs_nxt[ex_ra_r] = ex_wd_r;
        case (ex_ra_r)
          RA_WADDR: wph_nxt = 2'd0;
          RA_DATA: begin
            trip_nxt[wph_r] = ex_wd_r;
            pal_wr.data = {trip_nxt[0], trip_nxt[1], trip_nxt[2]};
            if (wph_r == 2'd2) begin
              pal_wr.we = ex_fire;
              wph_nxt = 2'd0;
              regs_nxt[RA_WADDR] = regs_r[RA_WADDR] + 8'd1;
            end else begin
              wph_nxt = wph_r + 2'd1;
            end
          end
          RA_RADDR: rph_nxt = 2'd0;
          RA_RESET: begin
            regs_nxt[RA_MASK]  = reg_default(RA_MASK);
            regs_nxt[RA_GCTL]  = reg_default(RA_GCTL);
            regs_nxt[RA_ICLK]  = reg_default(RA_ICLK);
            regs_nxt[RA_OCLK]  = reg_default(RA_OCLK);
            regs_nxt[RA_MUX]   = reg_default(RA_MUX);
            regs_nxt[RA_PAGE]  = reg_default(RA_PAGE);
            regs_nxt[RA_TEST]  = reg_default(RA_TEST);
            regs_nxt[RA_RESET] = reg_default(RA_RESET);
          end
          default: ;
        endcase
      end
      REQ_PIXEL: begin
        if ((ex_px_r & regs_r[RA_MASK]) == ex_px_r) begin
          res_r = pal_q[23:16];
          res_g = pal_q[15:8];
          res_b = pal_q[7:0];
          if (!dac_eight_bit_r) begin
            res_r = widen6(pal_q[23:16]);
            res_g = widen6(pal_q[15:8]);
            res_b = widen6(pal_q[7:0]);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dac_eight_bit_r <= 1'b1;
      for (int i = 0; i < 16; i++) begin
        regs_r[i] <= reg_default(4'(i));
      end
      for (int i = 0; i < 3; i++) begin
        trip_r[i] <= 8'd0;
      end
      wph_r       <= 2'd0;
      rph_r       <= 2'd0;
      ex_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dac_eight_bit_r <= cfg_wr_data;
      end
      if (ex_fire) begin
        regs_r <= regs_nxt;
        trip_r <= trip_nxt;
        wph_r  <= wph_nxt;
        rph_r  <= rph_nxt;
      end
      if (in_accept) begin
        ex_valid_r <= 1'b1;
      end else if (ex_fire) begin
        ex_valid_r <= 1'b0;
      end
      if (ex_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ex_req_r <= in_req_type;
      ex_ra_r  <= in_reg_addr;
      ex_wd_r  <= in_write_data;
      ex_px_r  <= in_pixel_index;
    end
    if (ex_fire) begin
      out_rd_r <= res_rd;
      out_r_r  <= res_r;
      out_g_r  <= res_g;
      out_b_r  <= res_b;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_rd_r;
  assign out_red_out   = out_r_r;
  assign out_green_out = out_g_r;
  assign out_blue_out  = out_b_r;

endmodule

// ===== rtl/prd_checker.sv =====
`include "palette_ramdac_registers_assert.svh"

module prd_checker
  import prd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data,
  input logic [7:0] out_red_out,
  input logic [7:0] out_green_out,
  input logic [7:0] out_blue_out
);

  // nothing leaves the block right after reset
  `PRD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  // input side only backs up behind a stalled result
  `PRD_ASSERT_RUN(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without cause")

  // an item is either a read or a lookup, never both
  `PRD_ASSERT_RUN(a_one_kind, (out_valid && (out_read_data != 8'd0)) |-> ((out_red_out == 8'd0) && (out_green_out == 8'd0) && (out_blue_out == 8'd0)), "read and color in one item")

  // stalled result holds
  `PRD_ASSERT_RUN(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_read_data) && $stable(out_red_out) && $stable(out_green_out) && $stable(out_blue_out)), "stalled result changed")

endmodule

bind palette_ramdac_registers prd_checker u_prd_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import prd_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] addr;
    logic [7:0] wdata;
    logic [7:0] pixel;
  } bus_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } dac_reply_t;

  class dac_shadow;
    logic [7:0]  regs [16];
    logic [7:0]  pal [PALETTE_ENTRIES][3];
    bit          filled [PALETTE_ENTRIES];
    logic [7:0]  filled_list[$];
    logic [7:0]  trip [3];
    int unsigned wr_phase;
    int unsigned rd_phase;
    bit          dac8;
    dac_reply_t  due[$];
    int          errors;

    function new();
      foreach (regs[k]) regs[k] = '0;
      foreach (pal[k]) begin
        pal[k][0] = '0;
        pal[k][1] = '0;
        pal[k][2] = '0;
        filled[k] = 1'b0;
      end
      foreach (trip[k]) trip[k] = '0;
      wr_phase = 0;
      rd_phase = 0;
      dac8 = 1'b1;
      errors = 0;
      load_defaults();
    endfunction

    function void load_defaults();
      regs[RA_MASK]  = 8'hff;
      regs[RA_GCTL]  = 8'h03;
      regs[RA_ICLK]  = 8'h00;
      regs[RA_OCLK]  = 8'h3f;
      regs[RA_MUX]   = 8'h2d;
      regs[RA_PAGE]  = 8'h00;
      regs[RA_TEST]  = 8'h00;
      regs[RA_RESET] = 8'h00;
    endfunction

    function logic [7:0] widen6(logic [7:0] v);
      return {v[5:0], v[5:4]};
    endfunction

    function logic [7:0] pick_filled();
      return filled_list[$urandom_range(filled_list.size() - 1)];
    endfunction

    // true when the item would fetch a palette entry that holds nothing yet
    function bit reads_unwritten(bus_item_t it);
      if (it.kind == REQ_READ && it.addr == RA_DATA && rd_phase == 0)
        return !filled[regs[RA_RADDR] % PALETTE_ENTRIES];
      if (it.kind == REQ_PIXEL && (it.pixel & regs[RA_MASK]) == it.pixel)
        return !filled[it.pixel % PALETTE_ENTRIES];
      return 1'b0;
    endfunction

    function dac_reply_t compute_reply(bus_item_t it);
      dac_reply_t  rep;
      int unsigned e;
      rep = '0;
      case (it.kind)
        REQ_READ: begin
          rep.data = regs[it.addr];
          if (it.addr == RA_DATA) begin
            if (rd_phase == 0) begin
              e = regs[RA_RADDR] % PALETTE_ENTRIES;
              foreach (trip[k]) trip[k] = pal[e][k];
            end
            rep.data = trip[rd_phase];
            rd_phase++;
            if (rd_phase == 3) begin
              rd_phase = 0;
              regs[RA_RADDR] = regs[RA_RADDR] + 8'd1;
            end
          end
        end
        REQ_WRITE: begin
          regs[it.addr] = it.wdata;
          if (it.addr == RA_WADDR) begin
            wr_phase = 0;
          end else if (it.addr == RA_DATA) begin
            trip[wr_phase] = it.wdata;
            wr_phase++;
            if (wr_phase == 3) begin
              e = regs[RA_WADDR] % PALETTE_ENTRIES;
              foreach (trip[k]) pal[e][k] = trip[k];
              if (!filled[e]) begin
                filled[e] = 1'b1;
                filled_list.push_back(8'(e));
              end
              wr_phase = 0;
              regs[RA_WADDR] = regs[RA_WADDR] + 8'd1;
            end
          end else if (it.addr == RA_RADDR) begin
            rd_phase = 0;
          end else if (it.addr == RA_RESET) begin
            load_defaults();
          end
        end
        REQ_PIXEL: begin
          if ((it.pixel & regs[RA_MASK]) == it.pixel) begin
            e = it.pixel % PALETTE_ENTRIES;
            rep.red   = pal[e][0];
            rep.green = pal[e][1];
            rep.blue  = pal[e][2];
            if (!dac8) begin
              rep.red   = widen6(rep.red);
              rep.green = widen6(rep.green);
              rep.blue  = widen6(rep.blue);
            end
          end
        end
        default: ;
      endcase
      return rep;
    endfunction

    function void note_request(bus_item_t it);
      due.push_back(compute_reply(it));
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %02h want %02h", name, got, want));
    endtask

    task check_reply(logic [7:0] data, logic [7:0] red, logic [7:0] green,
                     logic [7:0] blue);
      dac_reply_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected item %02h %02h %02h %02h", data, red, green, blue));
        return;
      end
      want = due.pop_front();
      compare_field("read_data", data, want.data);
      compare_field("red_out", red, want.red);
      compare_field("green_out", green, want.green);
      compare_field("blue_out", blue, want.blue);
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_req_type = '0;
  logic [3:0] in_reg_addr = '0;
  logic [7:0] in_write_data = '0;
  logic [7:0] in_pixel_index = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic [7:0] out_red_out;
  logic [7:0] out_green_out;
  logic [7:0] out_blue_out;

  dac_shadow   shadow;
  bit          sender_idles = 1'b1;
  bit          receiver_idles = 1'b1;
  int unsigned sent = 0;

  palette_ramdac_registers i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_reg_addr    (in_reg_addr),
    .in_write_data  (in_write_data),
    .in_pixel_index (in_pixel_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= receiver_idles && ($urandom_range(99) < 29);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      shadow.check_reply(out_read_data, out_red_out, out_green_out, out_blue_out);
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic send_item(bus_item_t it);
    while (sender_idles && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= it.kind;
    in_reg_addr    <= it.addr;
    in_write_data  <= it.wdata;
    in_pixel_index <= it.pixel;
    do @(posedge clk); while (in_stall);
    shadow.note_request(it);
    @(negedge clk);
  endtask

  task automatic issue(logic [1:0] req, logic [3:0] ra, logic [7:0] wd, logic [7:0] px);
    bus_item_t it;
    it = '{req, ra, wd, px};
    if (shadow.reads_unwritten(it)) return;
    send_item(it);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (shadow.due.size() != 0);
  endtask

  task automatic set_dac_mode(bit eight);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= eight;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    shadow.dac8 = eight;
  endtask

  task automatic palette_fill();
    int n;
    n = 3 * $urandom_range(1, 4);
    if ($urandom_range(99) < 15) n = $urandom_range(1, 5);
    if ($urandom_range(99) < 90) issue(REQ_WRITE, RA_WADDR, any_byte(), any_byte());
    repeat (n) issue(REQ_WRITE, RA_DATA, any_byte(), any_byte());
  endtask

  task automatic palette_readback();
    int n;
    if (shadow.filled_list.size() == 0) return;
    n = 3 * $urandom_range(1, 3);
    if ($urandom_range(99) < 15) n = $urandom_range(1, 5);
    issue(REQ_WRITE, RA_RADDR, shadow.pick_filled(), any_byte());
    repeat (n) issue(REQ_READ, RA_DATA, any_byte(), any_byte());
  endtask

  task automatic pixel_burst();
    int n;
    logic [7:0] px;
    if ($urandom_range(99) < 20) issue(REQ_WRITE, RA_MASK, 8'hff, any_byte());
    n = $urandom_range(1, 16);
    repeat (n) begin
      if (shadow.filled_list.size() != 0 && $urandom_range(99) < 80)
        px = shadow.pick_filled();
      else
        px = any_byte();
      issue(REQ_PIXEL, 4'($urandom_range(15)), any_byte(), px);
    end
  endtask

  task automatic register_poke();
    issue($urandom_range(1) ? REQ_WRITE : REQ_READ, 4'($urandom_range(15)),
          any_byte(), any_byte());
  endtask

  initial begin
    int unsigned goal;
    int unsigned pick;
    shadow = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // two full triplets, the second at the top entry so the address wraps
    issue(REQ_WRITE, RA_WADDR, 8'h00, 8'h00);
    issue(REQ_WRITE, RA_DATA, 8'hff, 8'hff);
    issue(REQ_WRITE, RA_DATA, 8'h00, 8'h00);
    issue(REQ_WRITE, RA_DATA, 8'ha5, 8'h5a);
    issue(REQ_WRITE, RA_WADDR, 8'hff, 8'h00);
    issue(REQ_WRITE, RA_DATA, 8'h3f, 8'h00);
    issue(REQ_WRITE, RA_DATA, 8'hc0, 8'h00);
    issue(REQ_WRITE, RA_DATA, 8'h7e, 8'h00);
    issue(REQ_READ, RA_WADDR, 8'h00, 8'h00);
    // readback of the top entry, read address wraps
    issue(REQ_WRITE, RA_RADDR, 8'hff, 8'h00);
    repeat (3) issue(REQ_READ, RA_DATA, 8'h00, 8'h00);
    issue(REQ_READ, RA_RADDR, 8'h00, 8'h00);
    issue(REQ_PIXEL, RA_WADDR, 8'h00, 8'h00);
    issue(REQ_PIXEL, RA_RESET, 8'hff, 8'hff);
    // pixel outside the read mask gives black
    issue(REQ_WRITE, RA_MASK, 8'h0f, 8'h00);
    issue(REQ_PIXEL, RA_WADDR, 8'h00, 8'hff);
    issue(REQ_PIXEL, RA_WADDR, 8'h00, 8'h00);
    // data write in the middle of a read triplet shares the staging bytes
    issue(REQ_WRITE, RA_RADDR, 8'h00, 8'h00);
    issue(REQ_READ, RA_DATA, 8'h00, 8'h00);
    issue(REQ_WRITE, RA_DATA, 8'h11, 8'h00);
    issue(REQ_READ, RA_DATA, 8'h00, 8'h00);
    // soft reset restores defaults
    issue(REQ_WRITE, RA_RESET, 8'h5a, 8'h00);
    issue(REQ_READ, RA_RESET, 8'h00, 8'h00);
    issue(REQ_READ, RA_MASK, 8'h00, 8'h00);
    issue(REQ_NONE, RA_RESET, 8'hff, 8'hff);

    for (int p = 0; p < 4; p++) begin
      drain();
      set_dac_mode(bit'(p % 2));
      sender_idles   = (p != 2);
      receiver_idles = (p != 2);
      goal = sent + 412;
      while (sent < goal) begin
        pick = $urandom_range(99);
        if (pick < 35)
          pixel_burst();
        else if (pick < 60)
          palette_fill();
        else if (pick < 80)
          palette_readback();
        else if (pick < 95)
          register_poke();
        else
          issue(REQ_NONE, 4'($urandom_range(15)), any_byte(), any_byte());
      end
    end

    drain();
    repeat (4) @(negedge clk);
    if (shadow.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
